[src/rcal_pkg.sv]
// Constants for the Republican calendar converter.
// No dependencies. Used by republican_calendar_from_day_count.
package rcal_pkg;

   localparam int unsigned DAYS_W    = 16;
   localparam int unsigned REM_W     = 17;
   localparam int unsigned YEAR_W    = 9;
   localparam int unsigned MONTH_W   = 5;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned DECADE_W  = 4;
   localparam int unsigned SUB_W     = 9;

   localparam logic [DAYS_W-1:0]  RESET_EPOCH_OFFSET = 16'd64748;
   localparam logic [SUB_W-1:0]   DAYS_COMMON        = 9'd365;
   localparam logic [SUB_W-1:0]   DAYS_LEAP          = 9'd366;
   localparam logic [SUB_W-1:0]   DAYS_MONTH         = 9'd30;
   localparam logic [SUB_W-1:0]   DAYS_COMP          = 9'd1;
   localparam logic [MONTH_W-1:0] REGULAR_MONTHS     = 5'd12;
   localparam logic [MONTH_W-1:0] LAST_COMP_MONTH    = 5'd17;
   localparam logic [YEAR_W-1:0]  EARLY_LEAP_END     = 9'd16;
   localparam logic [YEAR_W-1:0]  RULE_START_YEAR    = 9'd20;
   localparam logic [6:0]         CENTURY_LAST       = 7'd99;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_YEAR  = 2'd1;
   localparam logic [1:0] ST_MONTH = 2'd2;

endpackage

[src/republican_calendar_from_day_count.sv]
// Republican calendar date from a day count since the Unix epoch.
// One subtract/compare unit removes one year or one month per cycle, and the
// converter works on one word at a time.
// The next word is taken while a finished result waits in the output register.
// Reset (synchronous, active high) idles the sequencer, drops the output word and
// loads the epoch offset with 64748. Depends on rcal_pkg.
module republican_calendar_from_day_count
   import rcal_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [DAYS_W-1:0]   req_days_since_epoch,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [YEAR_W-1:0]   rsp_year,
   output logic [MONTH_W-1:0]  rsp_month_index,
   output logic [DAY_W-1:0]    rsp_day_of_month,
   output logic [DECADE_W-1:0] rsp_decade_day,
   output logic                rsp_leap_year,
   input  logic                csr_wr_en,
   input  logic [DAYS_W-1:0]   csr_wr_data
);

   logic [DAYS_W-1:0]   offset_ff;
   logic [1:0]          state_ff, state_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [6:0]          cent_pos_ff, cent_pos_in;   // year mod 100
   logic [1:0]          cent_cnt_ff, cent_cnt_in;   // (year div 100) mod 4
   logic [MONTH_W-1:0]  month_ff, month_in;
   logic                rsp_valid_ff;
   logic [YEAR_W-1:0]   year_out_ff;
   logic [MONTH_W-1:0]  month_out_ff;
   logic [DAY_W-1:0]    day_out_ff;
   logic [DECADE_W-1:0] decade_out_ff;
   logic                leap_out_ff;

   logic                accept;
   logic                out_free;
   logic                load_out;
   logic                leap;
   logic [SUB_W-1:0]    sub_val;
   logic [REM_W:0]      diff;
   logic                fits;
   logic                month_step;
   logic [DAY_W-1:0]    rem_low;
   logic [DAY_W-1:0]    decade_full;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Leap rule for the current year: early years 3, 7, 11 and 15 are leap,
   // the rest up to the rule start are common
   always_comb begin
      if (year_ff < RULE_START_YEAR) begin
         leap = (year_ff < EARLY_LEAP_END) && (year_ff[1:0] == 2'd3);
      end else begin
         leap = (year_ff[1:0] == 2'd0) && ((cent_pos_ff != 7'd0) || (cent_cnt_ff == 2'd0));
      end
   end

   // Shared subtract/compare unit: year length or month length
   always_comb begin
      if (state_ff == ST_YEAR) begin
         sub_val = leap ? DAYS_LEAP : DAYS_COMMON;
      end else if (month_ff < REGULAR_MONTHS) begin
         sub_val = DAYS_MONTH;
      end else begin
         sub_val = DAYS_COMP;
      end
   end

   assign diff = {1'b0, rem_ff} - {{(REM_W+1-SUB_W){1'b0}}, sub_val};
   assign fits = !diff[REM_W];

   // Sixth complementary day exists only in leap years
   assign month_step = fits && ((month_ff < LAST_COMP_MONTH) ||
                                ((month_ff == LAST_COMP_MONTH) && leap));
   assign load_out   = (state_ff == ST_MONTH) && !month_step && out_free;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      year_in     = year_ff;
      cent_pos_in = cent_pos_ff;
      cent_cnt_in = cent_cnt_ff;
      month_in    = month_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rem_in      = {1'b0, offset_ff} + {1'b0, req_days_since_epoch};
               year_in     = {{(YEAR_W-1){1'b0}}, 1'b1};
               cent_pos_in = 7'd1;
               cent_cnt_in = 2'd0;
               month_in    = '0;
               state_in    = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (fits) begin
               rem_in  = diff[REM_W-1:0];
               year_in = year_ff + 1'b1;
               if (cent_pos_ff == CENTURY_LAST) begin
                  cent_pos_in = 7'd0;
                  cent_cnt_in = cent_cnt_ff + 1'b1;
               end else begin
                  cent_pos_in = cent_pos_ff + 1'b1;
               end
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (month_step) begin
               rem_in   = diff[REM_W-1:0];
               month_in = month_ff + 1'b1;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Day fields: remainder is below 30 once months are removed
   assign rem_low = rem_ff[DAY_W-1:0];
   always_comb begin
      if (rem_low >= 5'd20) begin
         decade_full = rem_low - 5'd20;
      end else if (rem_low >= 5'd10) begin
         decade_full = rem_low - 5'd10;
      end else begin
         decade_full = rem_low;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= RESET_EPOCH_OFFSET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working and output words
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      year_ff     <= year_in;
      cent_pos_ff <= cent_pos_in;
      cent_cnt_ff <= cent_cnt_in;
      month_ff    <= month_in;
      if (load_out) begin
         year_out_ff   <= year_ff;
         month_out_ff  <= month_ff;
         day_out_ff    <= rem_low + 1'b1;
         decade_out_ff <= decade_full[DECADE_W-1:0];
         leap_out_ff   <= leap;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = year_out_ff;
   assign rsp_month_index  = month_out_ff;
   assign rsp_day_of_month = day_out_ff;
   assign rsp_decade_day   = decade_out_ff;
   assign rsp_leap_year    = leap_out_ff;

   // Year loop leaves less than one leap year of days
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (rem_ff < {{(REM_W-SUB_W){1'b0}}, DAYS_LEAP}))
      else $error("remainder too large after year loop");

   // Accepted word starts the year loop
   a_accept_year: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_YEAR))
      else $error("accepted word did not start year loop");

   // Complementary days fall on day one, first day of the decade
   a_comp_day: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_month_index >= REGULAR_MONTHS)) |->
      ((rsp_day_of_month == 5'd1) && (rsp_decade_day == 4'd0)))
      else $error("complementary day fields wrong");

   // Day of month stays within a month and the year is never zero
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_day_of_month != 5'd0) && (rsp_day_of_month <= 5'd30)
                     && (rsp_year != '0)))
      else $error("result day or year out of range");

endmodule
